### rtl/core/pidaw_pkg.sv
// pidaw_pkg: shared types and constants for the PID controller with anti-windup.
// Holds the configuration record, result record, register indexes and Q0.16 gains.
// No dependencies; used by every module under rtl/core.
package pidaw_pkg;

  // Default accumulator width for the integral term
  localparam int IntegralWidthDef = 32;

  // Q0.16 gains: 0.3, 0.07 and 0.2
  localparam logic signed [15:0] GainP = 16'sd19661;
  localparam logic signed [15:0] GainI = 16'sd4588;
  localparam logic signed [15:0] GainD = 16'sd13107;

  // Reset values of the output limits
  localparam logic signed [15:0] OutMinRst = 16'sh8000;
  localparam logic signed [15:0] OutMaxRst = 16'sh7fff;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TARGET   = 2'd0,
    CFG_DEADZONE = 2'd1,
    CFG_OUT_MIN  = 2'd2,
    CFG_OUT_MAX  = 2'd3
  } cfg_index_t;

  // Configuration register contents
  typedef struct packed {
    logic signed [15:0] target;
    logic        [14:0] deadzone;
    logic signed [15:0] out_min;
    logic signed [15:0] out_max;
  } cfg_t;

  // Per-item result from the datapath
  typedef struct packed {
    logic signed [15:0] drive;
    logic               clamped;
    logic               in_dz;
  } res_t;

endpackage

### rtl/core/pidaw_cfg_regs.sv
// pidaw_cfg_regs: configuration register file (target, deadzone, limits).
// Decodes writes from the cfg channel by register index.
// Depends on pidaw_pkg.
module pidaw_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [15:0]        wr_data,
  output pidaw_pkg::cfg_t    cfg
);

  pidaw_pkg::cfg_t cfg_r;

  // Register write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target   <= '0;
      cfg_r.deadzone <= '0;
      cfg_r.out_min  <= pidaw_pkg::OutMinRst;
      cfg_r.out_max  <= pidaw_pkg::OutMaxRst;
    end else if (wr_en) begin
      unique case (pidaw_pkg::cfg_index_t'(wr_index))
        pidaw_pkg::CFG_TARGET:   cfg_r.target   <= wr_data;
        pidaw_pkg::CFG_DEADZONE: cfg_r.deadzone <= wr_data[14:0];
        pidaw_pkg::CFG_OUT_MIN:  cfg_r.out_min  <= wr_data;
        pidaw_pkg::CFG_OUT_MAX:  cfg_r.out_max  <= wr_data;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/pidaw_datapath.sv
// pidaw_datapath: single-pass PID arithmetic for one error sample.
// Dead zone test, conditional integration, gain sum, truncation and clamp.
// Depends on pidaw_pkg.
module pidaw_datapath #(
  parameter int INTEGRAL_WIDTH = pidaw_pkg::IntegralWidthDef
) (
  input  logic signed [15:0]               error,
  input  pidaw_pkg::cfg_t                  cfg,
  input  logic signed [INTEGRAL_WIDTH-1:0] integral,
  input  logic signed [15:0]               prev_error,
  input  logic signed [15:0]               prev_drive,
  input  logic                             clamp_flag,
  output pidaw_pkg::res_t                  res,
  output logic signed [INTEGRAL_WIDTH-1:0] integral_nxt
);

  localparam int IntExtWidth = INTEGRAL_WIDTH + 1;
  localparam int SumWidth    = INTEGRAL_WIDTH + 17;
  localparam int QWidth      = SumWidth - 16;

  localparam logic signed [INTEGRAL_WIDTH-1:0] IntMax = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
  localparam logic signed [INTEGRAL_WIDTH-1:0] IntMin = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

  logic signed [16:0]               err_ext;
  logic signed [16:0]               mag;
  logic                             in_dz;
  logic signed [16:0]               deriv;
  logic                             hold;
  logic signed [IntExtWidth-1:0]    isum;
  logic signed [INTEGRAL_WIDTH-1:0] isat;
  logic signed [INTEGRAL_WIDTH-1:0] integ_use;
  logic signed [SumWidth-1:0]       term_p;
  logic signed [SumWidth-1:0]       term_i;
  logic signed [SumWidth-1:0]       term_d;
  logic signed [SumWidth-1:0]       sum;
  logic signed [SumWidth-1:0]       bias;
  logic signed [SumWidth-1:0]       sum_adj;
  logic signed [QWidth-1:0]         q;
  logic signed [QWidth-1:0]         min_ext;
  logic signed [QWidth-1:0]         max_ext;
  logic signed [15:0]               pid_drive;
  logic                             pid_clamped;

  // Dead zone: |error| <= deadzone
  assign err_ext = 17'(error);
  assign mag     = error[15] ? -err_ext : err_ext;
  assign in_dz   = (mag <= $signed({2'b00, cfg.deadzone}));

  assign deriv = 17'(error) - 17'(prev_error);

  // Integration is held while the last result was clamped and the previous drive
  // and the integral share a nonzero sign
  assign hold = clamp_flag && (prev_drive != '0) && (integral != '0) &&
                (prev_drive[15] == integral[INTEGRAL_WIDTH-1]);

  // Saturating accumulate
  assign isum = IntExtWidth'(integral) + IntExtWidth'(error);
  always_comb begin
    if (isum[IntExtWidth-1] != isum[IntExtWidth-2]) begin
      isat = isum[IntExtWidth-1] ? IntMin : IntMax;
    end else begin
      isat = isum[INTEGRAL_WIDTH-1:0];
    end
  end
  assign integ_use    = hold ? integral : isat;
  assign integral_nxt = in_dz ? integral : integ_use;

  // Gain sum, constant multiplies
  assign term_p = SumWidth'(error)     * SumWidth'(pidaw_pkg::GainP);
  assign term_i = SumWidth'(integ_use) * SumWidth'(pidaw_pkg::GainI);
  assign term_d = SumWidth'(deriv)     * SumWidth'(pidaw_pkg::GainD);
  assign sum    = term_p + term_i + term_d;

  // Divide by 2^16, rounding toward zero
  assign bias    = sum[SumWidth-1] ? SumWidth'(65535) : '0;
  assign sum_adj = sum + bias;
  assign q       = QWidth'(sum_adj >>> 16);

  // Clamp: low limit checked first, so reversed limits favor out_min
  assign min_ext = QWidth'(cfg.out_min);
  assign max_ext = QWidth'(cfg.out_max);
  always_comb begin
    priority if (q < min_ext) begin
      pid_drive   = cfg.out_min;
      pid_clamped = 1'b1;
    end else if (q > max_ext) begin
      pid_drive   = cfg.out_max;
      pid_clamped = 1'b1;
    end else begin
      pid_drive   = q[15:0];
      pid_clamped = 1'b0;
    end
  end

  assign res.drive   = in_dz ? cfg.target : pid_drive;
  assign res.clamped = in_dz ? 1'b0 : pid_clamped;
  assign res.in_dz   = in_dz;

endmodule

### rtl/core/pid_controller_antiwindup.sv
// pid_controller_antiwindup: top level of the PID controller with anti-windup.
// Depends on pidaw_pkg, pidaw_cfg_regs and pidaw_datapath.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_error) carries one control error per
//    transaction. Output channel (out_valid/out_ready/out_drive/out_clamped)
//    returns exactly one clamped drive per input transaction, in order.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes target,
//    deadzone, out_min and out_max; cfg_ready is always high. Write only while
//    no transaction is in flight.
//  - Path: an accepted error is held in the input register, and its result is
//    loaded into the output register when that register is empty or drains.
//  - Throughput: one transaction per cycle while out_ready is high. Integral,
//    previous drive and (outside the dead zone) previous error and clamp flag
//    update in the cycle the result is formed, so the next sample sees them at once.
//  - Reset (rst_n low, synchronous) clears the state to zero, the limits to
//    full range, and empties both registers.
//  - When out_ready is low, the output register holds; one more error can be
//    taken into the input register, after which in_ready drops.
module pid_controller_antiwindup #(
  parameter int INTEGRAL_WIDTH = pidaw_pkg::IntegralWidthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_error,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_drive,
  output logic               out_clamped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  pidaw_pkg::cfg_t                  cfg;
  pidaw_pkg::res_t                  res;
  logic signed [INTEGRAL_WIDTH-1:0] integral_nxt;

  logic                             in_valid_r;
  logic signed [15:0]               error_r;
  logic                             out_valid_r;
  logic signed [15:0]               out_drive_r;
  logic                             out_clamped_r;
  logic signed [INTEGRAL_WIDTH-1:0] integral_r;
  logic signed [15:0]               prev_error_r;
  logic signed [15:0]               prev_drive_r;
  logic                             clamp_flag_r;
  logic                             advance;
  logic                             step;

  assign cfg_ready = 1'b1;

  pidaw_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pidaw_datapath #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_datapath (
    .error        (error_r),
    .cfg          (cfg),
    .integral     (integral_r),
    .prev_error   (prev_error_r),
    .prev_drive   (prev_drive_r),
    .clamp_flag   (clamp_flag_r),
    .res          (res),
    .integral_nxt (integral_nxt)
  );

  // Handshake: output register drains or is empty, input register refills
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;
  assign step     = advance && in_valid_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      error_r <= in_error;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_drive_r   <= res.drive;
      out_clamped_r <= res.clamped;
    end
  end

  // Controller state; error and clamp flag kept only outside the dead zone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r   <= '0;
      prev_error_r <= '0;
      prev_drive_r <= '0;
      clamp_flag_r <= 1'b0;
    end else if (step) begin
      integral_r   <= integral_nxt;
      prev_drive_r <= res.drive;
      if (!res.in_dz) begin
        prev_error_r <= error_r;
        clamp_flag_r <= res.clamped;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_clamped = out_clamped_r;

  // Dead zone items leave the integral untouched
  a_dz_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.in_dz) |=> $stable(integral_r))
    else $error("integral changed on a dead zone transaction");

  // Kept state matches the result just issued
  a_state_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !res.in_dz) |=> (clamp_flag_r == out_clamped_r) &&
                             (prev_drive_r == out_drive_r))
    else $error("clamp flag or previous drive out of step with result");

  // A clamped result sits on one of the limits
  a_clamp_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clamped_r) |->
      (out_drive_r == cfg.out_min) || (out_drive_r == cfg.out_max))
    else $error("clamped drive is not at a limit");

  // An empty output register never blocks the input side
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

### verif/pid_drive_checker.sv
// pid_drive_checker: watches the error, drive and register channels of the PID block,
// predicts every drive from its own copy of the controller state and compares in order.
// Depends on pidaw_pkg for the register record, register indexes, gains and reset limits.
module pid_drive_checker #(
  parameter int INTEGRAL_WIDTH = pidaw_pkg::IntegralWidthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_error,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_drive,
  input  logic               out_clamped,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 checked_count,
  output int                 clamp_count,
  output int                 deadzone_count,
  output int                 hold_count,
  output int                 sat_count
);

  localparam longint IntHi = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint IntLo = -IntHi - 1;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               clamped;
  } drive_exp_t;

  // Expected drives, oldest first
  drive_exp_t drive_q[$];
  drive_exp_t want;

  // Shadow of the controller state and registers
  pidaw_pkg::cfg_t    regs;
  longint             integ;
  logic signed [15:0] prev_err;
  logic signed [15:0] prev_drv;
  logic               clamp_st;

  int n_fail, n_checked, n_clamp, n_dz, n_hold, n_sat;

  // One control step: dead zone, conditional integration, Q0.16 sum, clamp
  function automatic drive_exp_t predict_drive(input logic signed [15:0] e);
    longint     mag, d, acc, q, v, lo, hi;
    drive_exp_t r;
    mag = (e < 0) ? -longint'(e) : longint'(e);
    if (mag <= longint'(regs.deadzone)) begin
      n_dz++;
      prev_drv = regs.target;
      r.drive = regs.target;
      r.clamped = 1'b0;
      return r;
    end
    d = longint'(e) - longint'(prev_err);
    // hold the integral while the last drive was limited in the windup direction
    if (clamp_st && prev_drv != 0 && integ != 0 && ((prev_drv < 0) == (integ < 0))) begin
      n_hold++;
    end else begin
      integ = integ + longint'(e);
      if (integ > IntHi) begin
        integ = IntHi;
        n_sat++;
      end else if (integ < IntLo) begin
        integ = IntLo;
        n_sat++;
      end
    end
    acc = longint'(pidaw_pkg::GainP) * longint'(e) + longint'(pidaw_pkg::GainI) * integ +
          longint'(pidaw_pkg::GainD) * d;
    q = acc / longint'(65536);  // truncates toward zero
    prev_err = e;
    lo = longint'($signed(regs.out_min));
    hi = longint'($signed(regs.out_max));
    if (q < lo) v = lo;
    else if (q > hi) v = hi;
    else v = q;
    r.drive = 16'(v);
    r.clamped = (v != q);
    clamp_st = r.clamped;
    prev_drv = r.drive;
    if (r.clamped) n_clamp++;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.target = '0;
      regs.deadzone = '0;
      regs.out_min = pidaw_pkg::OutMinRst;
      regs.out_max = pidaw_pkg::OutMaxRst;
      integ = 0;
      prev_err = '0;
      prev_drv = '0;
      clamp_st = 1'b0;
      drive_q.delete();
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (pidaw_pkg::cfg_index_t'(cfg_index))
          pidaw_pkg::CFG_TARGET:   regs.target = cfg_data;
          pidaw_pkg::CFG_DEADZONE: regs.deadzone = cfg_data[14:0];
          pidaw_pkg::CFG_OUT_MIN:  regs.out_min = cfg_data;
          pidaw_pkg::CFG_OUT_MAX:  regs.out_max = cfg_data;
          default: ;
        endcase
      end
      // drive transaction against the oldest expectation
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          n_fail++;
          $error("unexpected drive transaction: drive %0d clamped %0b",
                 out_drive, out_clamped);
        end else begin
          want = drive_q.pop_front();
          n_checked++;
          if (out_drive !== want.drive) begin
            n_fail++;
            $error("field drive: expected %0d, actual %0d", want.drive, out_drive);
          end
          if (out_clamped !== want.clamped) begin
            n_fail++;
            $error("field clamped: expected %0b, actual %0b", want.clamped, out_clamped);
          end
        end
      end
      // error transaction
      if (in_valid && in_ready) drive_q.push_back(predict_drive(in_error));
    end
    fail_count <= n_fail;
    pending <= drive_q.size();
    checked_count <= n_checked;
    clamp_count <= n_clamp;
    deadzone_count <= n_dz;
    hold_count <= n_hold;
    sat_count <= n_sat;
  end

  initial begin
    n_fail = 0;
    n_checked = 0;
    n_clamp = 0;
    n_dz = 0;
    n_hold = 0;
    n_sat = 0;
  end

endmodule

### verif/pid_controller_antiwindup_test.sv
// pid_controller_antiwindup_test: drives errors and register writes into the PID block,
// paces the drive channel, and reports the verdict from pid_drive_checker.
// Depends on pidaw_pkg, pid_drive_checker and pid_controller_antiwindup.
module pid_controller_antiwindup_test;

  localparam int IntW = pidaw_pkg::IntegralWidthDef;
  localparam int CycleLimit = 2_000_000;
  localparam int RandItems = 1800;
  localparam int LongHold = 300;
  // full-scale errors pushed against limits pinned at zero, each direction
  localparam int SatUpItems = 100;
  localparam int SatDownItems = 100;

  typedef enum int {
    SEQ_WALK,
    SEQ_PUSH,
    SEQ_NOISE,
    SEQ_EDGE
  } seq_kind_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_error = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_drive;
  logic               out_clamped;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = pidaw_pkg::CFG_TARGET;
  logic [15:0]        cfg_data = '0;

  int fail_count, pending, checked_count, clamp_count;
  int deadzone_count, hold_count, sat_count;
  int cycles = 0;
  int n_settings = 0;
  int cur_dz = 0;
  bit tx_live = 1'b0;
  bit hold_req = 1'b0;
  bit burst_mode = 1'b0;

  pid_controller_antiwindup #(.INTEGRAL_WIDTH(IntW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_error(in_error),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_drive(out_drive), .out_clamped(out_clamped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pid_drive_checker #(.INTEGRAL_WIDTH(IntW)) drive_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_error(in_error),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_drive(out_drive), .out_clamped(out_clamped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked_count(checked_count),
    .clamp_count(clamp_count), .deadzone_count(deadzone_count),
    .hold_count(hold_count), .sat_count(sat_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("pid_controller_antiwindup_test: FAIL");
      $finish;
    end
  end

  // One error transaction, optionally after a random gap
  task automatic send_error(input logic signed [15:0] e, input bit paced);
    int gap;
    int r;
    gap = 0;
    if (paced && !burst_mode) begin
      r = $urandom_range(0, 99);
      if (r >= 97) gap = $urandom_range(20, 60);
      else if (r >= 88) gap = $urandom_range(4, 12);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      if (tx_live) begin
        in_valid <= 1'b0;
        tx_live = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_error <= e;
    tx_live = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait for every outstanding drive
  task automatic drain();
    if (tx_live) begin
      in_valid <= 1'b0;
      tx_live = 1'b0;
    end
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input pidaw_pkg::cfg_index_t idx, input logic [15:0] data);
    drain();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pidaw_pkg::CFG_DEADZONE) cur_dz = int'(data[14:0]);
    n_settings++;
  endtask

  // Drive channel pacing: random stalls, quiet stretches, and one long hold on request
  initial begin
    int  gap;
    int  mode_left;
    int  r;
    bit  quiet;
    bit  hold_seen;
    gap = 0;
    mode_left = 0;
    quiet = 1'b0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        gap = LongHold;
      end
      if (mode_left == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(40, 250);
      end else begin
        mode_left--;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && !burst_mode) begin
          r = $urandom_range(0, 99);
          if (r >= 98) gap = $urandom_range(20, 60);
          else if (r >= 90) gap = $urandom_range(4, 12);
          else if (r >= 65) gap = $urandom_range(1, 3);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int                 k;
    int                 sent;
    int                 goal;
    int                 len;
    int                 walk;
    int                 stp;
    int                 sgn;
    int                 sel;
    int                 a;
    seq_kind_t          kind;
    bit                 paced;
    logic               pad;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] tgt;
    logic signed [15:0] e;
    logic [14:0]        dz;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset limits, zero dead zone (zero error sits on its edge)
    send_error(16'sd0, 1'b1);
    send_error(16'sh7fff, 1'b1);
    send_error(16'sh8000, 1'b1);
    send_error(16'sd1, 1'b1);
    send_error(-16'sd1, 1'b1);
    // narrow limits: clamp, then hold while windup continues, then release
    write_reg(pidaw_pkg::CFG_OUT_MIN, -16'sd100);
    write_reg(pidaw_pkg::CFG_OUT_MAX, 16'sd100);
    send_error(16'sh7fff, 1'b1);
    send_error(16'sh7fff, 1'b1);
    send_error(16'sh8000, 1'b1);
    send_error(16'sh8000, 1'b1);
    // upper limit at zero: clamped, but a zero drive never holds the integral
    write_reg(pidaw_pkg::CFG_OUT_MAX, 16'sd0);
    send_error(16'sd20000, 1'b1);
    send_error(16'sd20000, 1'b1);
    // reversed limits
    write_reg(pidaw_pkg::CFG_OUT_MIN, 16'sd50);
    write_reg(pidaw_pkg::CFG_OUT_MAX, -16'sd50);
    send_error(16'sd1000, 1'b1);
    send_error(-16'sd3, 1'b1);
    send_error(-16'sd20000, 1'b1);
    // dead zone boundary, target outside the limits
    write_reg(pidaw_pkg::CFG_TARGET, -16'sd7);
    write_reg(pidaw_pkg::CFG_DEADZONE, 16'd100);
    send_error(16'sd100, 1'b1);
    send_error(-16'sd100, 1'b1);
    send_error(16'sd101, 1'b1);
    send_error(-16'sd101, 1'b1);
    // widest dead zone (top data bit set, not part of the register)
    write_reg(pidaw_pkg::CFG_TARGET, 16'sh7fff);
    write_reg(pidaw_pkg::CFG_DEADZONE, 16'hffff);
    send_error(16'sh7fff, 1'b1);
    send_error(16'sh8000, 1'b1);
    write_reg(pidaw_pkg::CFG_TARGET, 16'sh8000);
    write_reg(pidaw_pkg::CFG_DEADZONE, 16'd0);
    send_error(16'sd0, 1'b1);

    // Random phases: a fresh register setting, then shaped error sequences
    sent = 0;
    sel = 0;
    while (sent < RandItems) begin
      tgt = 16'($urandom);
      dz = 15'($urandom_range(0, 50));
      case ($urandom_range(0, 6))
        0: begin
          lo = 16'sh8000;
          hi = 16'sh7fff;
        end
        1: begin
          lo = 16'(-int'($urandom_range(1, 3000)));
          hi = 16'($urandom_range(1, 3000));
          tgt = 16'($urandom_range(0, 40)) - 16'sd20;
        end
        2: begin
          if ($urandom_range(0, 1) == 1) begin
            lo = 16'sd0;
            hi = 16'($urandom_range(1, 5000));
          end else begin
            lo = 16'(-int'($urandom_range(1, 5000)));
            hi = 16'sd0;
          end
        end
        3: begin
          lo = 16'($urandom_range(1, 2000));
          hi = 16'(-int'($urandom_range(0, 2000)));
        end
        4: begin
          lo = 16'($urandom);
          hi = lo;
        end
        5: begin
          a = $urandom_range(0, 30000);
          lo = 16'(-a);
          hi = 16'(a + int'($urandom_range(0, 2767)));
          dz = ($urandom_range(0, 3) == 0) ? 15'h7fff : 15'($urandom_range(500, 32766));
        end
        default: begin
          lo = 16'($urandom);
          hi = 16'($urandom);
          dz = 15'($urandom);
        end
      endcase
      pad = 1'($urandom_range(0, 1));
      write_reg(pidaw_pkg::CFG_TARGET, tgt);
      write_reg(pidaw_pkg::CFG_DEADZONE, {pad, dz});
      write_reg(pidaw_pkg::CFG_OUT_MIN, lo);
      write_reg(pidaw_pkg::CFG_OUT_MAX, hi);

      // second setting: drive channel held off while errors keep coming
      if (sel == 1) begin
        hold_req = ~hold_req;
        for (k = 0; k < 40; k++) begin
          send_error(16'($urandom), 1'b0);
          sent++;
        end
      end

      goal = sent + $urandom_range(120, 300);
      while (sent < goal) begin
        a = $urandom_range(0, 9);
        if (a <= 4) kind = SEQ_WALK;
        else if (a <= 7) kind = SEQ_PUSH;
        else if (a == 8) kind = SEQ_NOISE;
        else kind = SEQ_EDGE;
        paced = ($urandom_range(0, 2) != 0);
        walk = int'($urandom_range(0, 65535)) - 32768;
        stp = 1 << $urandom_range(0, 11);
        sgn = ($urandom_range(0, 1) == 1) ? 1 : -1;
        case (kind)
          SEQ_WALK:  len = $urandom_range(10, 40);
          SEQ_PUSH:  len = $urandom_range(5, 30);
          SEQ_NOISE: len = $urandom_range(1, 8);
          default:   len = $urandom_range(1, 6);
        endcase
        for (k = 0; k < len; k++) begin
          case (kind)
            SEQ_WALK: begin
              walk = walk + int'($urandom_range(0, 2 * stp)) - stp;
              if (walk > 32767) walk = 32767;
              if (walk < -32768) walk = -32768;
              e = 16'(walk);
            end
            SEQ_PUSH: begin
              // sustained one-sided error winds the integral up
              if (sgn < 0 && $urandom_range(0, 7) == 0) e = 16'sh8000;
              else e = 16'(sgn * int'($urandom_range(500, 32767)));
            end
            SEQ_NOISE: e = 16'($urandom);
            default: begin
              case ($urandom_range(0, 7))
                0: e = 16'sh8000;
                1: e = 16'sh7fff;
                2: e = 16'(cur_dz);
                3: e = 16'(-cur_dz);
                4: e = 16'(cur_dz + 1);
                5: e = 16'(-(cur_dz + 1));
                6: e = 16'sd0;
                default: e = ($urandom_range(0, 1) == 1) ? 16'sd1 : -16'sd1;
              endcase
            end
          endcase
          send_error(e, paced);
          sent++;
        end
      end
      sel++;
    end

    // Sustained full-scale error: limits pinned at zero so the integral never holds
    burst_mode = 1'b1;
    write_reg(pidaw_pkg::CFG_TARGET, 16'sd0);
    write_reg(pidaw_pkg::CFG_DEADZONE, 16'd0);
    write_reg(pidaw_pkg::CFG_OUT_MIN, 16'sd0);
    write_reg(pidaw_pkg::CFG_OUT_MAX, 16'sd0);
    for (k = 0; k < SatUpItems; k++) send_error(16'sh7fff, 1'b0);
    for (k = 0; k < SatDownItems; k++) send_error(16'sh8000, 1'b0);
    burst_mode = 1'b0;
    write_reg(pidaw_pkg::CFG_OUT_MIN, 16'sh8000);
    write_reg(pidaw_pkg::CFG_OUT_MAX, 16'sh7fff);
    for (k = 0; k < 30; k++) send_error(16'($urandom), 1'b1);

    drain();
    repeat (20) @(posedge clk);
    $display("checked %0d drives over %0d register writes: %0d limited, %0d in the dead zone",
             checked_count, n_settings, clamp_count, deadzone_count);
    $display("integral held %0d times and saturated %0d times", hold_count, sat_count);
    if (fail_count == 0) begin
      $display("pid_controller_antiwindup_test: PASS");
    end else begin
      $display("pid_controller_antiwindup_test: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/pidaw_pkg.sv
rtl/core/pidaw_cfg_regs.sv
rtl/core/pidaw_datapath.sv
rtl/core/pid_controller_antiwindup.sv
verif/pid_drive_checker.sv
verif/pid_controller_antiwindup_test.sv
